@@ rtl/nipw_pkg.sv @@
`timescale 1ns / 1ps
package nipw_pkg;

  localparam int PICK_RADIUS = 10;
  localparam int SIDE        = 2 * PICK_RADIUS;
  localparam int POS_W       = $clog2(SIDE);
  localparam int ID_W        = 24;
  localparam int LIMIT_W     = 25;
  localparam int DIST_W      = 8;
  localparam int MAX_DIST    = 2 * PICK_RADIUS * PICK_RADIUS;

  localparam logic [DIST_W-1:0] NO_DIST = '1;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
  } nipw_hit_t;

  // square of (pos - PICK_RADIUS)
  function automatic logic [DIST_W-1:0] sq_offset(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0]  mag;
    logic [DIST_W-1:0] m;
    if (pos >= POS_W'(PICK_RADIUS)) begin
      mag = pos - POS_W'(PICK_RADIUS);
    end else begin
      mag = POS_W'(PICK_RADIUS) - pos;
    end
    m = DIST_W'(mag);
    return m * m;
  endfunction

endpackage

@@ rtl/nipw_scan.sv @@
`timescale 1ns / 1ps
module nipw_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pix_en,
  input  logic [nipw_pkg::ID_W-1:0]  pix_id,
  input  logic                       pix_last,
  input  logic [nipw_pkg::LIMIT_W-1:0] id_limit,
  output nipw_pkg::nipw_hit_t        hit
);
  import nipw_pkg::*;

  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [ID_W-1:0]   best_id_r;
  logic [DIST_W-1:0] best_dist_r;
  logic              have_r;
  logic [DIST_W:0]   pix_dist;
  logic              take;

  assign pix_dist = {1'b0, sq_offset(row_r)} + {1'b0, sq_offset(col_r)};
  assign take = ({1'b0, pix_id} < id_limit) && (pix_dist < {1'b0, best_dist_r});

  // result including the current pixel
  always_comb begin
    hit.found   = have_r | take;
    hit.id      = take ? pix_id : best_id_r;
    hit.sq_dist = take ? pix_dist[DIST_W-1:0] : best_dist_r;
  end

  always_comb begin
    col_nxt = col_r + POS_W'(1);
    row_nxt = row_r;
    if (col_r == POS_W'(SIDE - 1)) begin
      col_nxt = '0;
      row_nxt = (row_r == POS_W'(SIDE - 1)) ? '0 : row_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      best_id_r   <= '0;
      best_dist_r <= NO_DIST;
      have_r      <= 1'b0;
    end else if (pix_en) begin
      if (pix_last) begin
        row_r       <= '0;
        col_r       <= '0;
        best_id_r   <= '0;
        best_dist_r <= NO_DIST;
        have_r      <= 1'b0;
      end else begin
        row_r       <= row_nxt;
        col_r       <= col_nxt;
        best_id_r   <= hit.id;
        best_dist_r <= hit.sq_dist;
        have_r      <= hit.found;
      end
    end
  end

endmodule

@@ rtl/nearest_id_pick_window.sv @@
`timescale 1ns / 1ps
// Nearest-ID pick over a square window of 2R x 2R pixels (R = PICK_RADIUS).
// in_*  : one pixel per beat, raster order; tdata = red, green, blue bytes
//         (red lowest), tlast marks the final pixel of the window.
// out_* : one beat per window, sent for the tlast pixel; tdata = hit_id,
//         hit_distance; tuser = hit_found.
// cfg_* : id_limit; decoded IDs at or above it are ignored. Write only while
//         the block is idle.
// Throughput: one pixel per cycle unless a tlast pixel meets an untaken
// result; the compare-and-keep against the best hit is combinational between
// the input register and the result register, which a tlast beat passes in turn.
// Pixel position is counted internally and wraps after 2R*2R pixels; tlast
// restarts the scan at the first row and column.
// Stall: a waiting result holds; pixels without tlast keep flowing, and the
// input stalls only when a second tlast pixel meets an untaken result.
// Reset (rst_n low, synchronous): scan state and id_limit clear, so no ID is
// valid until id_limit is written.
module nearest_id_pick_window (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_byte, green_byte, blue_byte
  input  logic        in_tlast,   // window_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // hit_id[23:0], hit_distance[31:24]
  output logic        out_tuser,  // hit_found
  input  logic        cfg_wr_en,
  input  logic [nipw_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import nipw_pkg::*;

  logic [LIMIT_W-1:0] id_limit_r;
  logic               s1_valid_r;
  logic [ID_W-1:0]    s1_id_r;
  logic               s1_last_r;
  logic               out_valid_r;
  nipw_hit_t          out_hit_r;
  nipw_hit_t          hit;
  logic               out_free;
  logic               s1_go;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r <= '0;
    end else if (cfg_wr_en) begin
      id_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_id_r   <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  nipw_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_en   (s1_go),
    .pix_id   (s1_id_r),
    .pix_last (s1_last_r),
    .id_limit (id_limit_r),
    .hit      (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_hit_r <= hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_hit_r.sq_dist, out_hit_r.id};
  assign out_tuser  = out_hit_r.found;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> out_valid_r)
    else $error("window end processed but no result raised");

  a_no_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tuser) |-> (out_tdata == {NO_DIST, {ID_W{1'b0}}}))
    else $error("empty result carries stale fields");

  a_hit_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser) |-> (out_tdata[31:24] <= DIST_W'(MAX_DIST)))
    else $error("hit distance out of range");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import nipw_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int WINDOW_PIXELS = SIDE * SIDE;
  localparam int NUM_PHASES    = 9;
  localparam int WINDOWS_PER_PHASE = 3;
  localparam int MAX_PRINTS    = 50;
  localparam logic [LIMIT_W-1:0] ALL_IDS = 25'h1000000;

  typedef enum int {WIN_SHORT, WIN_FULL, WIN_PARTIAL, WIN_LONG} win_kind_t;

  // Tracks the nearest valid ID per pick window and holds the hits still due.
  class pick_scoreboard;
    logic [LIMIT_W-1:0] id_limit;
    logic [POS_W-1:0]   row_pos;
    logic [POS_W-1:0]   col_pos;
    logic [ID_W-1:0]    best_id;
    logic [DIST_W-1:0]  best_dist;
    logic               have_hit;
    nipw_hit_t          expected_hits[$];
    int                 errors;

    function new();
      id_limit = '0;
      errors   = 0;
      clear_window();
    endfunction

    function void clear_window();
      row_pos   = '0;
      col_pos   = '0;
      best_id   = '0;
      best_dist = '1;
      have_hit  = 1'b0;
    endfunction

    task report(input string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void note_pixel(input logic [23:0] pixel, input logic last);
      int        di;
      int        dj;
      int        dsq;
      nipw_hit_t hit;
      di  = int'(row_pos) - PICK_RADIUS;
      dj  = int'(col_pos) - PICK_RADIUS;
      dsq = di * di + dj * dj;
      // strict compare: a tie keeps the earlier pixel
      if ({1'b0, pixel} < id_limit && dsq < int'(best_dist)) begin
        best_id   = pixel;
        best_dist = DIST_W'(dsq);
        have_hit  = 1'b1;
      end
      if (int'(col_pos) == SIDE - 1) begin
        col_pos = '0;
        row_pos = (int'(row_pos) == SIDE - 1) ? '0 : row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
      if (last) begin
        hit.found   = have_hit;
        hit.id      = have_hit ? best_id : '0;
        hit.sq_dist = have_hit ? best_dist : NO_DIST;
        expected_hits.push_back(hit);
        clear_window();
      end
    endfunction

    task check_hit(input logic [31:0] beat, input logic found);
      nipw_hit_t want;
      if (expected_hits.size() == 0) begin
        report($sformatf("unexpected result beat data=%h found=%b", beat, found));
      end else begin
        want = expected_hits.pop_front();
        if (found !== want.found)
          report($sformatf("hit_found %b, want %b", found, want.found));
        if (beat[23:0] !== want.id)
          report($sformatf("hit_id %h, want %h", beat[23:0], want.id));
        if (beat[31:24] !== want.sq_dist)
          report($sformatf("hit_distance %0d, want %0d", beat[31:24], want.sq_dist));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata = '0;   // red_byte, green_byte, blue_byte
  logic                in_tlast = 1'b0; // window_end
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;       // hit_id[23:0], hit_distance[31:24]
  logic                out_tuser;       // hit_found
  logic                cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wr_data = '0;

  int                  send_idle_pct = 16;
  int                  recv_stall_pct = 67;
  int unsigned         cycle_count = 0;
  pick_scoreboard      sb;

  nearest_id_pick_window DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_hit(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_pixel(input logic [ID_W-1:0] id, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drain all hits, let the pipeline settle, then write the limit.
  task automatic set_id_limit(input logic [LIMIT_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.id_limit = value;
  endtask

  function automatic logic [ID_W-1:0] pick_id(input int valid_pct);
    int unsigned span;
    span = (sb.id_limit >= ALL_IDS) ? 32'h1000000 : 32'(sb.id_limit);
    if ($urandom_range(9) == 0) return ID_W'($urandom());
    if ($urandom_range(99) < valid_pct) begin
      if (span == 0) return ID_W'($urandom());
      return ($urandom_range(3) == 0) ? ID_W'(span - 1) : ID_W'($urandom_range(span - 1));
    end
    if (span == 32'h1000000) return ID_W'($urandom());
    // hit the limit itself now and then
    return ($urandom_range(3) == 0) ? ID_W'(span) : ID_W'($urandom_range(32'hFFFFFF, span));
  endfunction

  task automatic send_random_window(input win_kind_t kind);
    int len;
    int valid_pct;
    case (kind)
      WIN_FULL:    len = WINDOW_PIXELS;
      WIN_PARTIAL: len = $urandom_range(WINDOW_PIXELS - 1, 25);
      WIN_LONG:    len = $urandom_range(WINDOW_PIXELS + 60, WINDOW_PIXELS + 1);
      default:     len = $urandom_range(20, 1);
    endcase
    // sparse windows let far pixels win before nearer ones show up
    valid_pct = ($urandom_range(1) == 0) ? $urandom_range(5) : $urandom_range(100);
    for (int k = 0; k < len; k++) send_pixel(pick_id(valid_pct), k == len - 1);
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limit;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty limit straight out of reset
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h000000, 1'b1);

    set_id_limit(ALL_IDS);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'hABCDEF, 1'b1);

    set_id_limit(25'd1);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h000000, 1'b1);

    set_id_limit(25'h0FFFFFF);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFFFFFE, 1'b1);

    set_id_limit(25'h0010000);
    send_pixel(24'h010000, 1'b0);
    send_pixel(24'h00FFFF, 1'b0);
    send_pixel(24'h0100FF, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_limit = ALL_IDS;
        1:       phase_limit = LIMIT_W'($urandom_range(300, 1));
        2:       phase_limit = '0;
        3:       phase_limit = LIMIT_W'($urandom_range(32'h1000000, 1));
        4:       phase_limit = 25'd1;
        5:       phase_limit = LIMIT_W'($urandom_range(65536, 1));
        6:       phase_limit = 25'h0FFFFFF;
        7:       phase_limit = LIMIT_W'($urandom_range(32'h1000000, 0));
        default: phase_limit = ALL_IDS;
      endcase
      if (p < 3) begin
        send_idle_pct  = 16;
        recv_stall_pct = 67;
      end else if (p < 6) begin
        send_idle_pct  = 67;
        recv_stall_pct = 16;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      set_id_limit(phase_limit);
      // one long window in each idling pattern
      case (p)
        0:       send_random_window(WIN_FULL);
        3:       send_random_window(WIN_LONG);
        6:       send_random_window(WIN_PARTIAL);
        default: ;
      endcase
      for (int w = 0; w < WINDOWS_PER_PHASE; w++) send_random_window(WIN_SHORT);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
